FILE: rtl/core/mck_pkg.sv
package mck_pkg;

   localparam int MCK_CHAR_W      = 8;
   localparam int MCK_UNIT_W      = 10;
   localparam int MCK_DUR_W       = 12;
   localparam int MCK_CNT_W       = 3;
   localparam int MCK_SYM_W       = 5;
   localparam int MCK_QUEUE_DEPTH = 2;

   localparam logic [MCK_UNIT_W-1:0] MCK_UNIT_RESET = 10'd100;

   localparam logic [MCK_CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [MCK_CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
   localparam logic [MCK_CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [MCK_CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
   localparam logic [MCK_CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [MCK_CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [MCK_CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [MCK_CHAR_W-1:0] CH_CASE_OFFSET = 8'h20;

   // one classified character; first symbol in the highest used bit, a set bit is a dah
   typedef struct packed {
      logic                 is_space;
      logic [MCK_CNT_W-1:0] count;
      logic [MCK_SYM_W-1:0] bits;
   } mck_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mck_q_status_type;

   function automatic mck_desc_type mck_pattern(input logic [MCK_CNT_W-1:0] count,
                                                input logic [MCK_SYM_W-1:0] bits);
      mck_desc_type d;
      d.is_space = 1'b0;
      d.count    = count;
      d.bits     = bits;
      return d;
   endfunction

   function automatic mck_desc_type mck_letter(input logic [4:0] idx);
      mck_desc_type d;
      unique case (idx)
         5'd0:    d = mck_pattern(3'd2, 5'h01);
         5'd1:    d = mck_pattern(3'd4, 5'h08);
         5'd2:    d = mck_pattern(3'd4, 5'h0a);
         5'd3:    d = mck_pattern(3'd3, 5'h04);
         5'd4:    d = mck_pattern(3'd1, 5'h00);
         5'd5:    d = mck_pattern(3'd4, 5'h02);
         5'd6:    d = mck_pattern(3'd3, 5'h06);
         5'd7:    d = mck_pattern(3'd4, 5'h00);
         5'd8:    d = mck_pattern(3'd2, 5'h00);
         5'd9:    d = mck_pattern(3'd4, 5'h07);
         5'd10:   d = mck_pattern(3'd3, 5'h05);
         5'd11:   d = mck_pattern(3'd4, 5'h04);
         5'd12:   d = mck_pattern(3'd2, 5'h03);
         5'd13:   d = mck_pattern(3'd2, 5'h02);
         5'd14:   d = mck_pattern(3'd3, 5'h07);
         5'd15:   d = mck_pattern(3'd4, 5'h06);
         5'd16:   d = mck_pattern(3'd4, 5'h0d);
         5'd17:   d = mck_pattern(3'd3, 5'h02);
         5'd18:   d = mck_pattern(3'd3, 5'h00);
         5'd19:   d = mck_pattern(3'd1, 5'h01);
         5'd20:   d = mck_pattern(3'd3, 5'h01);
         5'd21:   d = mck_pattern(3'd4, 5'h01);
         5'd22:   d = mck_pattern(3'd3, 5'h03);
         5'd23:   d = mck_pattern(3'd4, 5'h09);
         5'd24:   d = mck_pattern(3'd4, 5'h0b);
         5'd25:   d = mck_pattern(3'd4, 5'h0c);
         default: d = mck_pattern(3'd0, 5'h00);
      endcase
      return d;
   endfunction

   function automatic mck_desc_type mck_digit(input logic [3:0] idx);
      mck_desc_type d;
      unique case (idx)
         4'd0:    d = mck_pattern(3'd5, 5'h1f);
         4'd1:    d = mck_pattern(3'd5, 5'h0f);
         4'd2:    d = mck_pattern(3'd5, 5'h07);
         4'd3:    d = mck_pattern(3'd5, 5'h03);
         4'd4:    d = mck_pattern(3'd5, 5'h01);
         4'd5:    d = mck_pattern(3'd5, 5'h00);
         4'd6:    d = mck_pattern(3'd5, 5'h10);
         4'd7:    d = mck_pattern(3'd5, 5'h18);
         4'd8:    d = mck_pattern(3'd5, 5'h1c);
         4'd9:    d = mck_pattern(3'd5, 5'h1e);
         default: d = mck_pattern(3'd0, 5'h00);
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/core/mck_front.sv
module mck_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mck_pkg::MCK_CHAR_W-1:0] character,
   input  mck_pkg::mck_q_status_type      q_status,
   output logic                           busy,
   output logic                           push,
   output mck_pkg::mck_desc_type          push_desc
);
   import mck_pkg::*;

   logic                  valid_ff, valid_in;
   mck_desc_type          desc_ff, desc_in;
   logic [MCK_CHAR_W-1:0] folded;
   mck_desc_type          classified;
   logic                  accept;
   logic [MCK_CHAR_W-1:0] letter_off;
   logic [MCK_CHAR_W-1:0] digit_off;

   assign busy   = valid_ff && q_status.full;
   assign push   = valid_ff && !q_status.full;
   assign accept = start && !busy;
   assign push_desc = desc_ff;

   always_comb begin
      folded = character;
      if (character >= CH_UPPER_A && character <= CH_UPPER_Z) begin
         folded = character + CH_CASE_OFFSET;
      end
      letter_off = folded - CH_LOWER_A;
      digit_off  = folded - CH_DIGIT_0;
      classified = mck_pattern(3'd0, 5'h00);
      priority if (folded >= CH_LOWER_A && folded <= CH_LOWER_Z) begin
         classified = mck_letter(letter_off[4:0]);
      end else if (folded >= CH_DIGIT_0 && folded <= CH_DIGIT_9) begin
         classified = mck_digit(digit_off[3:0]);
      end else if (folded == CH_SPACE) begin
         classified.is_space = 1'b1;
      end else begin
         // unknown byte: letter gap only
         classified = mck_pattern(3'd0, 5'h00);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      desc_in  = desc_ff;
      if (accept) begin
         valid_in = 1'b1;
         desc_in  = classified;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      desc_ff <= desc_in;
   end

endmodule

FILE: rtl/core/mck_queue.sv
module mck_queue #(
   parameter int DEPTH = mck_pkg::MCK_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mck_pkg::mck_desc_type     push_desc,
   input  logic                      pop,
   output mck_pkg::mck_desc_type     pop_desc,
   output mck_pkg::mck_q_status_type status
);
   import mck_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mck_desc_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push  = push && !status.full;
   assign do_pop   = pop && !status.empty;
   assign pop_desc = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

FILE: rtl/core/mck_back.sv
module mck_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mck_pkg::MCK_UNIT_W-1:0] unit_ms,
   input  mck_pkg::mck_q_status_type      q_status,
   input  mck_pkg::mck_desc_type          pop_desc,
   output logic                           pop,
   output logic                           rsp_strobe,
   output logic                           rsp_light_on,
   output logic [mck_pkg::MCK_DUR_W-1:0]  rsp_duration_ms,
   output logic                           rsp_last
);
   import mck_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SPACE = 5'b00010,
      ST_ON    = 5'b00100,
      ST_OFF   = 5'b01000,
      ST_GAP   = 5'b10000
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [MCK_CNT_W-1:0] rem_ff, rem_in;
   logic [MCK_SYM_W-1:0] bits_ff, bits_in;
   logic                 strobe_ff, strobe_in;
   logic                 light_ff, light_in;
   logic [MCK_DUR_W-1:0] dur_ff, dur_in;
   logic                 last_ff, last_in;
   logic [MCK_DUR_W-1:0] dur_1u, dur_3u, dur_4u;
   logic [MCK_CNT_W-1:0] sym_idx;

   assign dur_1u = {2'b00, unit_ms};
   assign dur_3u = {2'b00, unit_ms} + {1'b0, unit_ms, 1'b0};
   assign dur_4u = {unit_ms, 2'b00};
   assign sym_idx = rem_ff - 1'b1;
   assign pop = (state_ff == ST_IDLE) && !q_status.empty;

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      bits_in   = bits_ff;
      strobe_in = 1'b0;
      light_in  = 1'b0;
      dur_in    = dur_1u;
      last_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               rem_in  = pop_desc.count;
               bits_in = pop_desc.bits;
               priority if (pop_desc.is_space) begin
                  state_in = ST_SPACE;
               end else if (pop_desc.count != '0) begin
                  state_in = ST_ON;
               end else begin
                  state_in = ST_GAP;
               end
            end
         end
         ST_SPACE: begin
            strobe_in = 1'b1;
            dur_in    = dur_4u;
            state_in  = ST_GAP;
         end
         ST_ON: begin
            strobe_in = 1'b1;
            light_in  = 1'b1;
            dur_in    = bits_ff[sym_idx] ? dur_3u : dur_1u;
            state_in  = ST_OFF;
         end
         ST_OFF: begin
            strobe_in = 1'b1;
            rem_in    = sym_idx;
            state_in  = (rem_ff == 3'd1) ? ST_GAP : ST_ON;
         end
         ST_GAP: begin
            strobe_in = 1'b1;
            dur_in    = dur_3u;
            last_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      rem_ff   <= rem_in;
      bits_ff  <= bits_in;
      light_ff <= light_in;
      dur_ff   <= dur_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_light_on    = light_ff;
   assign rsp_duration_ms = dur_ff;
   assign rsp_last        = last_ff;

endmodule

FILE: rtl/core/morse_character_keyer.sv
// channel   ports                                   transfer
// request   start, busy, req_character              start high and busy low at the edge
// result    rsp_strobe, rsp_light_on,               one cycle each, strobe marks it,
//           rsp_duration_ms, rsp_last               the receiver takes it at that edge
// csr       csr_valid, csr_ready, csr_unit_ms       valid and ready high at the edge
//
// a character gives 1 to 11 intervals, one per cycle, after the back sequencer fetches
// its entry from the queue in the idle state
// the front holds one character and the queue two more; busy rises while both are full
// results leave a registered output stage and cannot be held off
// synchronous reset clears the queue, the sequencer and sets the unit to 100 ms
module morse_character_keyer #(
   parameter int QUEUE_DEPTH = mck_pkg::MCK_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [mck_pkg::MCK_CHAR_W-1:0] req_character,
   output logic                           rsp_strobe,
   output logic                           rsp_light_on,
   output logic [mck_pkg::MCK_DUR_W-1:0]  rsp_duration_ms,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mck_pkg::MCK_UNIT_W-1:0] csr_unit_ms
);
   import mck_pkg::*;

   logic [MCK_UNIT_W-1:0] unit_ms_ff, unit_ms_in;
   mck_q_status_type      q_status;
   mck_desc_type          push_desc;
   mck_desc_type          pop_desc;
   logic                  push;
   logic                  pop;

   assign csr_ready  = 1'b1;
   assign unit_ms_in = (csr_valid && csr_ready) ? csr_unit_ms : unit_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ms_ff <= MCK_UNIT_RESET;
      end else begin
         unit_ms_ff <= unit_ms_in;
      end
   end

   mck_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .character (req_character),
      .q_status  (q_status),
      .busy      (busy),
      .push      (push),
      .push_desc (push_desc)
   );

   mck_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .status    (q_status)
   );

   mck_back u_back (
      .clock           (clock),
      .reset           (reset),
      .unit_ms         (unit_ms_ff),
      .q_status        (q_status),
      .pop_desc        (pop_desc),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_light_on    (rsp_light_on),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_last        (rsp_last)
   );

   // the letter gap is always dark
   a_last_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> (rsp_strobe && !rsp_light_on))
      else $error("letter gap with lamp lit");

   // every lit interval is followed at once by a dark one
   a_on_then_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_light_on) |=> (rsp_strobe && !rsp_light_on && !rsp_last))
      else $error("lit interval not followed by symbol space");

   // a run of intervals has no holes before its last one
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside an interval run");

   // the queue never reports full and empty at once
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty together");

endmodule
